FILE: rtl/drti_pkg.sv
package drti_pkg;

    localparam int MAX_RUNS = 64;
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);
    localparam int BLK_W    = 31;
    localparam int LEN_W    = 32;

    // result status codes
    localparam logic [2:0] ST_PREV  = 3'd0;
    localparam logic [2:0] ST_NEXT  = 3'd1;
    localparam logic [2:0] ST_NEW   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic             eval;
        logic             prev;
        logic             next;
        logic             ins;
        logic [BLK_W-1:0] blk;
    } t_cmd;

    // per-cell match flags back to the sequencer
    typedef struct packed {
        logic is_last;
        logic prev_hit;
        logic next_hit;
    } t_flags;

endpackage

FILE: rtl/drti_cell.sv
module drti_cell (
    input  logic                          i_clk,
    input  drti_pkg::t_cmd                i_cmd,
    input  logic                          i_occ,
    input  logic                          i_gt_left,
    input  logic                          i_gt_right,
    input  logic [drti_pkg::BLK_W-1:0]    i_start_left,
    input  logic [drti_pkg::LEN_W-1:0]    i_len_left,
    output logic                          o_gt,
    output logic [drti_pkg::BLK_W-1:0]    o_start,
    output logic [drti_pkg::LEN_W-1:0]    o_len,
    output drti_pkg::t_flags              o_flags
);

    logic [drti_pkg::BLK_W-1:0] r_start;
    logic [drti_pkg::LEN_W-1:0] r_len;
    logic                       r_gt;
    logic                       r_em;
    logic                       r_nm;
    logic [drti_pkg::BLK_W+1:0] w_end;
    logic [drti_pkg::BLK_W:0]   w_blk_inc;
    logic                       w_is_last;
    logic                       w_is_pos;

    assign w_end     = {2'b00, r_start} + {1'b0, r_len};
    assign w_blk_inc = {1'b0, i_cmd.blk} + {{drti_pkg::BLK_W{1'b0}}, 1'b1};
    assign w_is_last = r_gt & ~i_gt_right;
    assign w_is_pos  = i_gt_left & ~r_gt & i_occ;

    // match flags, taken while the stored run holds still
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_gt <= i_occ && (i_cmd.blk > r_start);
            r_em <= (w_end == {2'b00, i_cmd.blk});
            r_nm <= (r_start != '0) && (w_blk_inc == {1'b0, r_start});
        end
    end

    // run update: grow in place, grow downward, or shift right on insert
    always_ff @(posedge i_clk) begin
        if (i_cmd.prev && w_is_last) begin
            r_len <= r_len + {{(drti_pkg::LEN_W-1){1'b0}}, 1'b1};
        end else if (i_cmd.next && w_is_pos) begin
            r_start <= i_cmd.blk;
            r_len   <= r_len + {{(drti_pkg::LEN_W-1){1'b0}}, 1'b1};
        end else if (i_cmd.ins && !r_gt) begin
            if (i_gt_left) begin
                r_start <= i_cmd.blk;
                r_len   <= {{(drti_pkg::LEN_W-1){1'b0}}, 1'b1};
            end else begin
                r_start <= i_start_left;
                r_len   <= i_len_left;
            end
        end
    end

    assign o_gt             = r_gt;
    assign o_start          = r_start;
    assign o_len            = r_len;
    assign o_flags.is_last  = w_is_last;
    assign o_flags.prev_hit = w_is_last & r_em;
    assign o_flags.next_hit = w_is_pos & r_nm;

endmodule

FILE: rtl/defect_run_table_insert.sv
// defect run table insert: keeps up to drti_pkg::MAX_RUNS runs of defective
// blocks (start, length) sorted by start in a row of cells, one run per cell.
// each input word is either an insert (tuser op 0, tdata block number) or a
// clear (tuser op 1). an insert grows the run that ends at the block, else
// grows the following run downward when the block sits right below it, else
// opens a new one-block run in order, with the cells above it shifting one
// place up in the same cycle. runs are never merged. a new run on a full
// table is dropped and raises a sticky hard error that only a clear or a
// reset clears. every item gives exactly one result word. one item is worked
// at a time, in the steps accept, cell compare and commit: the result word is
// valid after the commit, and the next word is taken only once the commit is
// done. the commit waits as long as the previous result word has not been
// taken on i_m_tready; the compare cycle is the registered match stage inside
// every cell, the commit is the shift/grow step.
module defect_run_table_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] block, [31] zero fill
    input  logic [0:0]  i_s_tuser,   // [0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [2:0] status, [9:3] run_count, [10] hard_error, rest zero
);

    localparam int N = drti_pkg::MAX_RUNS;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic                       r_op;
    logic [drti_pkg::BLK_W-1:0] r_blk;
    logic [drti_pkg::CNT_W-1:0] r_count;
    logic                       r_err;
    logic                       r_out_valid;
    logic [2:0]                 r_out_status;
    logic [6:0]                 r_out_count;
    logic                       r_out_err;

    drti_pkg::t_cmd             w_cmd;
    drti_pkg::t_flags           w_flags [N];
    logic [N-1:0]               w_occ;
    logic [N-1:0]               w_gt;
    logic [N-1:0]               w_last_vec;
    logic [N-1:0]               w_prev_vec;
    logic [N-1:0]               w_next_vec;
    logic [drti_pkg::BLK_W-1:0] w_start [N];
    logic [drti_pkg::LEN_W-1:0] w_len   [N];
    logic                       w_accept;
    logic                       w_slot_free;
    logic                       w_commit;
    logic                       w_prev_hit;
    logic                       w_next_hit;
    logic                       w_full;
    logic [2:0]                 w_status;
    logic [drti_pkg::CNT_W-1:0] w_count;
    logic                       w_err;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_commit    = (r_state == S_COMMIT) && w_slot_free;

    // ---- row of cells, each with a fixed slot index -------------------------
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic                       w_gl;
            logic                       w_gr;
            logic [drti_pkg::BLK_W-1:0] w_sl;
            logic [drti_pkg::LEN_W-1:0] w_ll;

            // slot holds a live run when it sits below the run count
            assign w_occ[gi] = (r_count > drti_pkg::CNT_W'(gi));

            if (gi == 0) begin : g_first
                // nothing to the left: treat as "start below block"
                assign w_gl = 1'b1;
                assign w_sl = r_blk;
                assign w_ll = {{(drti_pkg::LEN_W-1){1'b0}}, 1'b1};
            end else begin : g_mid
                assign w_gl = w_gt[gi-1];
                assign w_sl = w_start[gi-1];
                assign w_ll = w_len[gi-1];
            end

            if (gi == N - 1) begin : g_tail
                assign w_gr = 1'b0;
            end else begin : g_body
                assign w_gr = w_gt[gi+1];
            end

            drti_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occ        (w_occ[gi]),
                .i_gt_left    (w_gl),
                .i_gt_right   (w_gr),
                .i_start_left (w_sl),
                .i_len_left   (w_ll),
                .o_gt         (w_gt[gi]),
                .o_start      (w_start[gi]),
                .o_len        (w_len[gi]),
                .o_flags      (w_flags[gi])
            );

            assign w_last_vec[gi] = w_flags[gi].is_last;
            assign w_prev_vec[gi] = w_flags[gi].prev_hit;
            assign w_next_vec[gi] = w_flags[gi].next_hit;
        end
    endgenerate

    // ---- decision from the registered cell flags ----------------------------
    assign w_prev_hit = |w_prev_vec;
    assign w_next_hit = |w_next_vec;
    assign w_full     = (r_count == drti_pkg::CNT_W'(N));

    always_comb begin
        w_status = drti_pkg::ST_NEW;
        w_count  = r_count;
        w_err    = r_err;
        priority if (r_op) begin
            w_status = drti_pkg::ST_CLEAR;
            w_count  = '0;
            w_err    = 1'b0;
        end else if (w_prev_hit) begin
            w_status = drti_pkg::ST_PREV;
        end else if (w_next_hit) begin
            w_status = drti_pkg::ST_NEXT;
        end else if (w_full) begin
            w_status = drti_pkg::ST_FULL;
            w_err    = 1'b1;
        end else begin
            w_status = drti_pkg::ST_NEW;
            w_count  = r_count + {{(drti_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
    end

    // broadcast to the cells
    always_comb begin
        w_cmd.eval = (r_state == S_EVAL);
        w_cmd.prev = w_commit && (w_status == drti_pkg::ST_PREV);
        w_cmd.next = w_commit && (w_status == drti_pkg::ST_NEXT);
        w_cmd.ins  = w_commit && (w_status == drti_pkg::ST_NEW);
        w_cmd.blk  = r_blk;
    end

    // ---- sequencer ----------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= w_count;
                r_err       <= w_err;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser[0];
            r_blk <= i_s_tdata[drti_pkg::BLK_W-1:0];
        end
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_count  <= w_count[6:0];
            r_out_err    <= w_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000, r_out_err, r_out_count, r_out_status};

    // ---- checks -------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= drti_pkg::CNT_W'(N))
        else $error("run count above table size");

    a_sorted_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> $onehot0(w_last_vec))
        else $error("cell compare flags are not a prefix, table out of order");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> ($onehot0(w_prev_vec) && $onehot0(w_next_vec)))
        else $error("more than one cell claims the block");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted item did not enter the compare cycle");

    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (w_status == drti_pkg::ST_FULL)) |=> (r_err && r_out_err))
        else $error("dropped insert did not raise the hard error");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_op) |=> (r_count == '0 && !r_err && r_out_count == 7'd0))
        else $error("clear left runs or error behind");

endmodule
